// ===== hw/rtl/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types, codes and helpers for the adjacency power-sum block.
// ----------------------------------------------------------------------------
package aps_pkg;

   // matrix size is fixed by the 5-bit indexes and the 32-bit row word
   localparam int MaxNodes = 32;
   localparam int NodeW    = $clog2(MaxNodes);
   localparam int CellW    = 2 * NodeW;
   localparam int Cells    = MaxNodes * MaxNodes;
   localparam int CountW   = NodeW + 1;
   localparam int PowerW   = 5;
   localparam int SumW     = 64;

   // request operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // register indexes
   localparam logic REG_NODE_COUNT  = 1'b0;
   localparam logic REG_POWER_COUNT = 1'b1;

   // queued command kinds
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_COMPUTE = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [NodeW-1:0]    row;
      logic [NodeW-1:0]    col;
      logic [MaxNodes-1:0] bits;
      logic                zero;   // read outside the matrix in use
   } cmd_type;

   typedef struct packed {
      logic boot_clear;
   } eng_status_type;

   // nodes in use: the register clipped to the matrix size
   function automatic logic [CountW-1:0] nodes_in_use(input logic [5:0] node_count);
      logic [CountW-1:0] n;
      if (node_count > 6'(MaxNodes)) begin
         n = CountW'(MaxNodes);
      end else begin
         n = CountW'(node_count);
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/aps_ram.sv =====
// ----------------------------------------------------------------------------
// aps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aps_ram #(
   parameter int Width = 64,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/aps_front.sv =====
// ----------------------------------------------------------------------------
// aps_front
// Request decode and a two-word command queue in front of the engine.
// ----------------------------------------------------------------------------
module aps_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_operation,
   input  logic [aps_pkg::NodeW-1:0]        req_row_index,
   input  logic [aps_pkg::NodeW-1:0]        req_col_index,
   input  logic [aps_pkg::MaxNodes-1:0]     req_row_bits,
   input  logic [aps_pkg::CountW-1:0]       nodes,
   input  aps_pkg::eng_status_type          status,
   output logic                             cmd_valid,
   output aps_pkg::cmd_type                 cmd,
   input  logic                             cmd_pop
);

   aps_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   aps_pkg::cmd_type dec;
   logic             keep;
   logic             accept;
   logic             push;
   logic             row_out, col_out;

   assign busy   = (count_ff == 2'd2) || status.boot_clear;
   assign accept = start && !busy;

   // decode: drop undefined codes and loads outside the matrix
   always_comb begin
      row_out    = aps_pkg::CountW'(req_row_index) >= nodes;
      col_out    = aps_pkg::CountW'(req_col_index) >= nodes;
      dec.row    = req_row_index;
      dec.col    = req_col_index;
      dec.bits   = req_row_bits;
      dec.zero   = row_out || col_out;
      dec.kind   = aps_pkg::CMD_LOAD;
      keep       = 1'b0;
      unique case (req_operation)
         aps_pkg::OP_LOAD: begin
            dec.kind = aps_pkg::CMD_LOAD;
            keep     = !row_out;
         end
         aps_pkg::OP_COMPUTE: begin
            dec.kind = aps_pkg::CMD_COMPUTE;
            keep     = 1'b1;
         end
         aps_pkg::OP_READ: begin
            dec.kind = aps_pkg::CMD_READ;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push      = accept && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== hw/rtl/aps_engine.sv =====
// ----------------------------------------------------------------------------
// aps_engine
// Back end: adjacency rows, power and sum memories, and the compute sequencer.
// ----------------------------------------------------------------------------
module aps_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [aps_pkg::CountW-1:0]  nodes,
   input  logic [aps_pkg::PowerW-1:0]  powers,
   input  logic                        cmd_valid,
   input  aps_pkg::cmd_type            cmd,
   output logic                        cmd_pop,
   output aps_pkg::eng_status_type     status,
   output logic                        rsp_valid,
   output logic [aps_pkg::SumW-1:0]    rsp_sum_entry
);

   localparam int NW = aps_pkg::NodeW;
   localparam int CW = aps_pkg::CellW;
   localparam int SW = aps_pkg::SumW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_INIT  = 3'd2;
   localparam logic [2:0] ST_MAC   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_WB    = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic                          boot_ff, boot_in;
   logic [NW-1:0]                 i_ff, i_in, j_ff, j_in, m_ff, m_in;
   logic [aps_pkg::PowerW-1:0]    p_ff, p_in;
   logic                          bank_ff, bank_in;
   logic [CW-1:0]                 clr_ff, clr_in;
   logic [SW-1:0]                 acc_ff, acc_in;
   logic [SW-1:0]                 s_old_ff, s_old_in;
   logic                          pend_ff, pend_in;
   logic                          pend_first_ff, pend_first_in;
   logic                          pend_edge_ff, pend_edge_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_zero_ff, rsp_zero_in;
   logic [aps_pkg::MaxNodes-1:0]  adj_ff [aps_pkg::MaxNodes];
   logic                          adj_we;

   logic [NW-1:0]                 last;
   logic [NW-1:0]                 edge_sel;
   logic [aps_pkg::MaxNodes-1:0]  edge_row;
   logic                          edge_bit;

   logic          p_we, p_re;
   logic [CW:0]   p_waddr, p_raddr;
   logic [SW-1:0] p_wdata, p_rdata;
   logic          s_we, s_re;
   logic [CW-1:0] s_waddr, s_raddr;
   logic [SW-1:0] s_wdata, s_rdata;

   aps_ram #(.Width(SW), .Depth(2 * aps_pkg::Cells)) u_power_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   aps_ram #(.Width(SW), .Depth(aps_pkg::Cells)) u_sum_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign last      = NW'(nodes - aps_pkg::CountW'(1));
   assign edge_sel  = (state_ff == ST_INIT) ? i_ff : m_ff;
   assign edge_row  = adj_ff[edge_sel];
   assign edge_bit  = edge_row[j_ff];

   assign status.boot_clear = boot_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sum_entry     = rsp_zero_ff ? '0 : s_rdata;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      boot_in       = boot_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      bank_in       = bank_ff;
      clr_in        = clr_ff;
      pend_in       = 1'b0;
      pend_first_in = 1'b0;
      pend_edge_in  = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_zero_in   = rsp_zero_ff;
      cmd_pop       = 1'b0;
      adj_we        = 1'b0;
      p_we          = 1'b0;
      p_waddr       = '0;
      p_wdata       = '0;
      p_re          = 1'b0;
      p_raddr       = '0;
      s_we          = 1'b0;
      s_waddr       = '0;
      s_wdata       = '0;
      s_re          = 1'b0;
      s_raddr       = '0;

      // accumulate the power word read last cycle
      acc_in   = acc_ff;
      s_old_in = s_old_ff;
      if (pend_ff) begin
         acc_in = (pend_first_ff ? '0 : acc_ff) + (pend_edge_ff ? p_rdata : '0);
         if (pend_first_ff) begin
            s_old_in = s_rdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  aps_pkg::CMD_LOAD: begin
                     adj_we = 1'b1;
                  end
                  aps_pkg::CMD_READ: begin
                     s_re         = 1'b1;
                     s_raddr      = {cmd.row, cmd.col};
                     rsp_valid_in = 1'b1;
                     rsp_zero_in  = cmd.zero;
                  end
                  aps_pkg::CMD_COMPUTE: begin
                     if (nodes == '0) begin
                        state_in = ST_IDLE;
                     end else if (powers == '0) begin
                        state_in = ST_CLEAR;
                        clr_in   = '0;
                     end else begin
                        state_in = ST_INIT;
                        i_in     = '0;
                        j_in     = '0;
                        bank_in  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            s_we    = 1'b1;
            s_waddr = clr_ff;
            clr_in  = clr_ff + CW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
               boot_in  = 1'b0;
            end
         end
         ST_INIT: begin
            p_we    = 1'b1;
            p_waddr = {1'b0, i_ff, j_ff};
            p_wdata = SW'(edge_bit);
            s_we    = 1'b1;
            s_waddr = {i_ff, j_ff};
            s_wdata = SW'(edge_bit);
            j_in    = j_ff + NW'(1);
            if (j_ff == last) begin
               j_in = '0;
               i_in = i_ff + NW'(1);
               if (i_ff == last) begin
                  i_in     = '0;
                  m_in     = '0;
                  p_in     = aps_pkg::PowerW'(2);
                  state_in = (powers == aps_pkg::PowerW'(1)) ? ST_IDLE : ST_MAC;
               end
            end
         end
         ST_MAC: begin
            p_re          = 1'b1;
            p_raddr       = {bank_ff, i_ff, m_ff};
            pend_in       = 1'b1;
            pend_first_in = (m_ff == '0);
            pend_edge_in  = edge_bit;
            if (m_ff == '0) begin
               s_re    = 1'b1;
               s_raddr = {i_ff, j_ff};
            end
            m_in = m_ff + NW'(1);
            if (m_ff == last) begin
               m_in     = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            p_we     = 1'b1;
            p_waddr  = {!bank_ff, i_ff, j_ff};
            p_wdata  = acc_ff;
            s_we     = 1'b1;
            s_waddr  = {i_ff, j_ff};
            s_wdata  = s_old_ff + acc_ff;
            state_in = ST_MAC;
            j_in     = j_ff + NW'(1);
            if (j_ff == last) begin
               j_in = '0;
               i_in = i_ff + NW'(1);
               if (i_ff == last) begin
                  // one power done: swap buffers
                  i_in    = '0;
                  bank_in = !bank_ff;
                  p_in    = p_ff + aps_pkg::PowerW'(1);
                  if (p_ff == powers) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      m_ff          <= m_in;
      p_ff          <= p_in;
      bank_ff       <= bank_in;
      acc_ff        <= acc_in;
      s_old_ff      <= s_old_in;
      pend_first_ff <= pend_first_in;
      pend_edge_ff  <= pend_edge_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   // adjacency rows, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < aps_pkg::MaxNodes; r++) begin
            adj_ff[r] <= '0;
         end
      end else if (adj_we) begin
         adj_ff[cmd.row] <= cmd.bits;
      end
   end

endmodule

// ===== hw/rtl/adjacency_power_sum_top.sv =====
// ----------------------------------------------------------------------------
// adjacency_power_sum_top
// Walk-count power series S = A + ... + A^k of a graph of up to 32 nodes.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  request   req_operation/row_index/col_index/row_bits   start, busy
//  response  rsp_sum_entry                                rsp_valid (1 cycle)
//  csr       csr_index, csr_wr_data                       csr_wr_en
//
//  The engine takes load and read words from the queue while idle; a read is
//  answered through the queue register and then the registered sum-memory read.
//  Compute copies A into the power and sum memories, then for each further power
//  does one power-memory read per multiply-add step; with k = 0 it clears all
//  1024 sum cells instead. After reset they are cleared likewise with busy high.
//  A two-word queue takes requests while the engine works; busy when full.
//  The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module adjacency_power_sum_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_operation,
   input  logic [aps_pkg::NodeW-1:0]      req_row_index,
   input  logic [aps_pkg::NodeW-1:0]      req_col_index,
   input  logic [aps_pkg::MaxNodes-1:0]   req_row_bits,
   output logic                           rsp_valid,
   output logic [aps_pkg::SumW-1:0]       rsp_sum_entry,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [5:0]                     csr_wr_data
);

   logic [5:0]                     node_count_ff, node_count_in;
   logic [aps_pkg::PowerW-1:0]     power_count_ff, power_count_in;
   logic [aps_pkg::CountW-1:0]     nodes;
   logic                           cmd_valid;
   logic                           cmd_pop;
   aps_pkg::cmd_type               cmd;
   aps_pkg::eng_status_type        status;

   // config registers
   always_comb begin
      node_count_in  = node_count_ff;
      power_count_in = power_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            aps_pkg::REG_NODE_COUNT:  node_count_in  = csr_wr_data;
            aps_pkg::REG_POWER_COUNT: power_count_in = csr_wr_data[aps_pkg::PowerW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= 6'd20;
         power_count_ff <= aps_pkg::PowerW'(1);
      end else begin
         node_count_ff  <= node_count_in;
         power_count_ff <= power_count_in;
      end
   end

   assign nodes = aps_pkg::nodes_in_use(node_count_ff);

   aps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_row_bits  (req_row_bits),
      .nodes         (nodes),
      .status        (status),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   aps_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .nodes         (nodes),
      .powers        (power_count_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_sum_entry (rsp_sum_entry)
   );

endmodule

// ===== test/tb_adjacency_power_sum_top.sv =====
// ----------------------------------------------------------------------------
// tb_adjacency_power_sum_top
// Self-checking bench for the walk-count power-sum block.
// Loads adjacency rows, runs power-sum computes across node/power settings
// (empty matrix, empty sum, clipped node count, largest sizes) and checks
// every read word against a behavioral walk-count predictor.
// ----------------------------------------------------------------------------
module tb_adjacency_power_sum_top;

   localparam logic [1:0] OP_NONE = 2'd3;   // ignored operation
   localparam int NumPhases = 8;
   localparam int CheapCompute = 40000;
   localparam int NodeW = aps_pkg::NodeW;
   localparam int MaxNodes = aps_pkg::MaxNodes;
   localparam int SumW = aps_pkg::SumW;
   localparam int Cells = aps_pkg::Cells;

   logic clock, reset, start, busy, rsp_valid, csr_wr_en, csr_index;
   logic [1:0]          req_operation;
   logic [NodeW-1:0]    req_row_index, req_col_index;
   logic [MaxNodes-1:0] req_row_bits;
   logic [SumW-1:0]     rsp_sum_entry;
   logic [5:0]          csr_wr_data;

   // predictor state
   logic [5:0]          node_cfg;
   logic [4:0]          power_cfg;
   logic [MaxNodes-1:0] adj_rows [MaxNodes];
   logic [SumW-1:0]     walk_pow [Cells];
   logic [SumW-1:0]     walk_next [Cells];
   logic [SumW-1:0]     walk_sums [Cells];
   logic [SumW-1:0]     pending_sums [$];
   bit                  failed;

   typedef struct {
      logic [1:0]          op;
      int                  row;
      int                  col;
      logic [MaxNodes-1:0] bits;
      bit                  typed;
      logic [SumW-1:0]     sum;
   } word_row_type;

   adjacency_power_sum_top i_dut (
      .clock, .reset, .start, .busy, .req_operation, .req_row_index,
      .req_col_index, .req_row_bits, .rsp_valid, .rsp_sum_entry,
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("adjacency_power_sum_top verification failed");
      $finish;
   end

   function automatic int nodes_used();
      return (node_cfg > 6'd32) ? 32 : int'(node_cfg);
   endfunction

   function automatic int compute_cycles(int n, int k);
      return n * n + ((k > 1) ? (k - 1) * n * n * (n + 2) : 0);
   endfunction

   // queue up one expected read word
   task automatic expect_sum(input logic [SumW-1:0] value);
      pending_sums = {pending_sums, value};
   endtask

   // S = A + ... + A^k over the nodes in use
   task automatic compute_walk_sums();
      int n, k;
      logic [SumW-1:0] acc;
      n = nodes_used();
      k = int'(power_cfg);
      if (n == 0) return;
      if (k == 0) begin
         foreach (walk_sums[c]) walk_sums[c] = '0;
         return;
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            walk_pow[i*MaxNodes+j]  = SumW'(adj_rows[i][j]);
            walk_sums[i*MaxNodes+j] = SumW'(adj_rows[i][j]);
         end
      for (int p = 2; p <= k; p++) begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               acc = '0;
               for (int m = 0; m < n; m++)
                  if (adj_rows[m][j]) acc += walk_pow[i*MaxNodes+m];
               walk_next[i*MaxNodes+j] = acc;
            end
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               walk_pow[i*MaxNodes+j]  = walk_next[i*MaxNodes+j];
               walk_sums[i*MaxNodes+j] += walk_next[i*MaxNodes+j];
            end
      end
   endtask

   // one request word; returns once it has been taken
   task automatic send_word(input logic [1:0] op, input int row, input int col,
                            input logic [MaxNodes-1:0] bits, input bit typed,
                            input logic [SumW-1:0] typed_sum);
      int gap, n;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_row_index <= NodeW'(row);
      req_col_index <= NodeW'(col);
      req_row_bits  <= bits;
      do @(posedge clock); while (busy);
      n = nodes_used();
      case (op)
         aps_pkg::OP_LOAD: begin
            if (row < n) adj_rows[row] = bits;
         end
         aps_pkg::OP_COMPUTE: begin
            compute_walk_sums();
         end
         aps_pkg::OP_READ: begin
            if (typed) expect_sum(typed_sum);
            else if (row < n && col < n) expect_sum(walk_sums[row*MaxNodes+col]);
            else expect_sum('0);
         end
         default: ;
      endcase
   endtask

   // a read word flushes any compute ahead of it; then let the engine settle
   task automatic drain();
      send_word(aps_pkg::OP_READ, 0, 0, '0, 1'b0, '0);
      start <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [5:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == aps_pkg::REG_NODE_COUNT) node_cfg = value;
      else power_cfg = value[4:0];
   endtask

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            $error("sum_entry: unexpected word, actual %h", rsp_sum_entry);
            failed = 1'b1;
         end else begin
            logic [SumW-1:0] want;
            want = pending_sums.pop_front();
            if (rsp_sum_entry !== want) begin
               $error("sum_entry: expected %h actual %h", want, rsp_sum_entry);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      word_row_type directed [$];
      int phase_nodes [NumPhases] = '{20, 0, 1, 5, 63, 3, 7, 32};
      int phase_power [NumPhases] = '{1, 3, 1, 0, 2, 31, 4, 16};
      int n, row, col, pick;
      logic [1:0] op;

      failed = 1'b0;
      start = 1'b0; req_operation = aps_pkg::OP_LOAD; req_row_index = '0;
      req_col_index = '0; req_row_bits = '0; csr_wr_en = 1'b0;
      csr_index = aps_pkg::REG_NODE_COUNT; csr_wr_data = '0;
      node_cfg = 6'd20; power_cfg = 5'd1;
      foreach (adj_rows[r]) adj_rows[r] = '0;
      foreach (walk_sums[c]) begin
         walk_sums[c] = '0; walk_pow[c] = '0; walk_next[c] = '0;
      end
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings (20 nodes, power 1)
      directed = '{
         '{aps_pkg::OP_READ,     0,  0, '0,            1'b1, '0}, // read before compute
         '{aps_pkg::OP_READ,    31, 31, '0,            1'b1, '0},
         '{OP_NONE,              3,  4, '1,            1'b0, '0}, // ignored operation
         '{aps_pkg::OP_LOAD,     0,  0, 32'hFFFF_FFFF, 1'b0, '0}, // columns beyond n too
         '{aps_pkg::OP_LOAD,    19,  0, 32'h0000_0001, 1'b0, '0},
         '{aps_pkg::OP_LOAD,     5,  0, 32'h0000_0000, 1'b0, '0},
         '{aps_pkg::OP_LOAD,    25,  0, 32'hFFFF_FFFF, 1'b0, '0}, // load beyond n
         '{aps_pkg::OP_LOAD,    31,  0, 32'hAAAA_5555, 1'b0, '0},
         '{aps_pkg::OP_COMPUTE,  0,  0, '0,            1'b0, '0},
         '{aps_pkg::OP_READ,     0,  0, '0,            1'b0, '0},
         '{aps_pkg::OP_READ,     0, 19, '0,            1'b0, '0},
         '{aps_pkg::OP_READ,    19,  0, '0,            1'b0, '0},
         '{aps_pkg::OP_READ,    25,  3, '0,            1'b1, '0}, // read beyond n
         '{aps_pkg::OP_READ,     3, 31, '0,            1'b1, '0},
         '{aps_pkg::OP_READ,     5,  5, '0,            1'b0, '0}
      };
      foreach (directed[d])
         send_word(directed[d].op, directed[d].row, directed[d].col, directed[d].bits,
                   directed[d].typed, directed[d].sum);

      // random words over a sweep of settings
      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph > 0) begin
            drain();
            write_reg(aps_pkg::REG_NODE_COUNT, 6'(phase_nodes[ph]));
            write_reg(aps_pkg::REG_POWER_COUNT, 6'(phase_power[ph]));
         end
         n = nodes_used();
         for (int it = 0; it < 6; it++) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) op = aps_pkg::OP_LOAD;
            else if (pick < 17) op = aps_pkg::OP_READ;
            else if (pick < 19) op = aps_pkg::OP_COMPUTE;
            else op = OP_NONE;
            if (op == aps_pkg::OP_COMPUTE &&
                compute_cycles(n, int'(power_cfg)) > CheapCompute)
               op = aps_pkg::OP_READ;
            row = (n == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                         : $urandom_range(0, n - 1);
            col = (n == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                         : $urandom_range(0, n - 1);
            send_word(op, row, col, $urandom(), 1'b0, '0);
         end
         // one compute per setting, then a few reads of it
         send_word(aps_pkg::OP_COMPUTE, 0, 0, '0, 1'b0, '0);
         for (int it = 0; it < 4; it++) begin
            row = $urandom_range(0, (n == 0) ? 31 : n - 1);
            col = $urandom_range(0, (n == 0) ? 31 : n - 1);
            send_word(aps_pkg::OP_READ, row, col, '0, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("adjacency_power_sum_top verification clean");
      end else begin
         $display("adjacency_power_sum_top verification failed");
      end
      $finish;
   end

endmodule
